FILE: hdl/lif_pkg.sv
// Shared types, constants and the decay factor table for the LIF neuron array.
// No dependencies; lif_ctrl, lif_dp and the top level import this package.
package lif_pkg;

   localparam int NEURONS_DEF = 64;
   localparam int DIV_STEPS   = 56;
   localparam int DEC_STEPS   = 22;
   localparam logic [55:0] DECAY_LIMIT = 56'(46) << 16;

   typedef enum logic [2:0] {
      CSR_LEAK_TIME,
      CSR_REFRACTORY_TIME,
      CSR_SCALED_THRESHOLD,
      CSR_BIPOLAR_OFFSET,
      CSR_BIPOLAR_INTEGRATION,
      CSR_BIPOLAR_THRESHOLD,
      CSR_TERMINATE_DELTA
   } lif_csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_DINIT,
      ST_DECAY,
      ST_SCALE,
      ST_UPDATE,
      ST_SCAN,
      ST_SCAN_END,
      ST_FIN,
      ST_DONE
   } lif_state_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic rd;
      logic start;
      logic div_step;
      logic dec_init;
      logic dec_step;
      logic scale;
      logic update;
      logic scan;
      logic scan_end;
      logic fin;
      logic out_load;
   } lif_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic leak_on;
      logic div_last;
      logic dec_last;
      logic need_scan;
      logic scan_last;
      logic out_free;
   } lif_sts_type;

   // round(2^32 * exp(-2^b / 65536)) for bit b of the Q40.16 ratio
   function automatic logic [31:0] lif_decay_tab(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd4294901760;
         5'd1:    v = 32'd4294836226;
         5'd2:    v = 32'd4294705160;
         5'd3:    v = 32'd4294443040;
         5'd4:    v = 32'd4293918848;
         5'd5:    v = 32'd4292870656;
         5'd6:    v = 32'd4290775039;
         5'd7:    v = 32'd4286586875;
         5'd8:    v = 32'd4278222805;
         5'd9:    v = 32'd4261543595;
         5'd10:   v = 32'd4228380000;
         5'd11:   v = 32'd4162825044;
         5'd12:   v = 32'd4034748382;
         5'd13:   v = 32'd3790295335;
         5'd14:   v = 32'd3344923893;
         5'd15:   v = 32'd2605029347;
         5'd16:   v = 32'd1580030169;
         5'd17:   v = 32'd581260616;
         5'd18:   v = 32'd78665070;
         5'd19:   v = 32'd1440801;
         5'd20:   v = 32'd483;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/lif_if.sv
// Valid/ready channel interfaces for spike items and result items.
// Depends on nothing.
interface lif_req_if;
   logic               valid;
   logic               ready;
   logic [5:0]         neuron;
   logic               negative;
   logic [39:0]        arrival_time;
   logic signed [23:0] weight;

   modport source(output valid, neuron, negative, arrival_time, weight, input ready);
   modport sink(input valid, neuron, negative, arrival_time, weight, output ready);
endinterface

interface lif_rsp_if;
   logic       valid;
   logic       ready;
   logic       fired;
   logic       fired_negative;
   logic [5:0] fired_neuron;
   logic       stop;

   modport source(output valid, fired, fired_negative, fired_neuron, stop, input ready);
   modport sink(input valid, fired, fired_negative, fired_neuron, stop, output ready);
endinterface

FILE: hdl/lif_ctrl.sv
// Sequencer for the LIF neuron array: clearing pass, per-item phases, result hand-off.
// Depends on lif_pkg.
module lif_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lif_pkg::lif_sts_type sts,
   output lif_pkg::lif_cmd_type cmd
);
   import lif_pkg::*;

   lif_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_READ;
         ST_READ:     state_in = ST_LOAD;
         ST_LOAD: begin
            if (!sts.in_range) state_in = ST_DONE;
            else if (sts.leak_on) state_in = ST_DIV;
            else state_in = ST_UPDATE;
         end
         ST_DIV:      if (sts.div_last) state_in = ST_DINIT;
         ST_DINIT:    state_in = ST_DECAY;
         ST_DECAY:    if (sts.dec_last) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_UPDATE;
         ST_UPDATE:   state_in = sts.need_scan ? ST_SCAN : ST_DONE;
         ST_SCAN:     if (sts.scan_last) state_in = ST_SCAN_END;
         ST_SCAN_END: state_in = ST_FIN;
         ST_FIN:      state_in = ST_DONE;
         ST_DONE:     if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:    cmd.clr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_READ:     cmd.rd = 1'b1;
         ST_LOAD:     cmd.start = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_DINIT:    cmd.dec_init = 1'b1;
         ST_DECAY:    cmd.dec_step = 1'b1;
         ST_SCALE:    cmd.scale = 1'b1;
         ST_UPDATE:   cmd.update = 1'b1;
         ST_SCAN:     cmd.scan = 1'b1;
         ST_SCAN_END: cmd.scan_end = 1'b1;
         ST_FIN:      cmd.fin = 1'b1;
         ST_DONE:     cmd.out_load = sts.out_free;
         default:     cmd = '0;
      endcase
   end

endmodule

FILE: hdl/lif_dp.sv
// Datapath of the LIF neuron array: neuron state memories, config registers,
// restoring divider, decay multiplier, integrate/fire logic, count scan, result register.
// Depends on lif_pkg.
module lif_dp #(
   parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lif_pkg::lif_cmd_type cmd,
   output lif_pkg::lif_sts_type sts,
   input  logic [5:0]           req_neuron,
   input  logic                 req_negative,
   input  logic [39:0]          req_arrival_time,
   input  logic signed [23:0]   req_weight,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_fired,
   output logic                 rsp_fired_negative,
   output logic [5:0]           rsp_fired_neuron,
   output logic                 rsp_stop
);
   import lif_pkg::*;

   localparam int AW = $clog2(NEURONS);
   localparam logic [AW-1:0] LAST_IDX = AW'(NEURONS - 1);
   localparam logic signed [16:0] CNT_FLOOR = -17'sd32769;

   logic signed [31:0] pot_mem  [NEURONS];
   logic [39:0]        last_mem [NEURONS];
   logic [39:0]        rend_mem [NEURONS];
   logic signed [15:0] cnt_mem  [NEURONS];

   logic [31:0] leak_ff;
   logic [31:0] refr_ff;
   logic [30:0] thr_ff;
   logic [30:0] off_ff;
   logic        bint_ff;
   logic        bthr_ff;
   logic [15:0] delta_ff;

   logic [AW-1:0]      clr_idx_ff;
   logic [5:0]         n_ff;
   logic               neg_ff;
   logic [39:0]        t_ff;
   logic signed [23:0] w_ff;

   logic signed [31:0] rd_pot_ff;
   logic [39:0]        rd_last_ff;
   logic [39:0]        rd_rend_ff;
   logic signed [15:0] rd_cnt_ff;

   logic signed [31:0] p_ff;
   logic [55:0]        quo_ff;
   logic [32:0]        rem_ff;
   logic [5:0]         div_cnt_ff;
   logic [31:0]        f_ff;
   logic               f_one_ff;
   logic               zero_ff;
   logic [4:0]         dec_idx_ff;

   logic [AW-1:0]      sc_idx_ff;
   logic               sv_ff;
   logic signed [16:0] top_ff;
   logic signed [16:0] sec_ff;

   logic fired_ff, fneg_ff, stop_ff;
   logic out_valid_ff, out_fired_ff, out_fneg_ff, out_stop_ff;
   logic [5:0] out_n_ff;

   logic [AW-1:0] n_addr;
   logic          in_range;
   logic [39:0]   dt;
   logic [32:0]   trial;
   logic          trial_ge;
   logic [63:0]   dec_prod;
   logic [63:0]   dec_round;
   logic [31:0]   mag;
   logic [63:0]   sc_prod;
   logic [63:0]   sc_round;
   logic [31:0]   mag2;

   logic signed [33:0] w_ext;
   logic signed [33:0] add_v;
   logic signed [33:0] sum_v;
   logic signed [31:0] psat;
   logic signed [32:0] thr_s;
   logic signed [32:0] psat_neg;
   logic               fire_c;
   logic               fneg_c;
   logic signed [32:0] pnew_wide;
   logic signed [31:0] pnew;
   logic signed [15:0] cnew;
   logic signed [16:0] scan_v;
   logic signed [17:0] lead;

   assign n_addr   = AW'(n_ff);
   assign in_range = 32'(n_ff) < NEURONS;
   assign dt       = t_ff - rd_last_ff;

   assign trial    = {rem_ff[31:0], quo_ff[55]};
   assign trial_ge = trial >= {1'b0, leak_ff};

   assign dec_prod  = f_ff * lif_decay_tab(dec_idx_ff);
   assign dec_round = dec_prod + 64'h0000_0000_8000_0000;

   assign mag      = p_ff[31] ? (~p_ff + 32'd1) : p_ff;
   assign sc_prod  = mag * f_ff;
   assign sc_round = sc_prod + 64'h0000_0000_8000_0000;
   assign mag2     = sc_round[63:32];

   always_comb begin
      w_ext = 34'(w_ff);
      add_v = bint_ff ? ((w_ext <<< 1) - $signed({3'b000, off_ff})) : w_ext;
      sum_v = neg_ff ? (34'(p_ff) - add_v) : (34'(p_ff) + add_v);
      if (sum_v > 34'sh0_7FFF_FFFF) psat = 32'sh7FFF_FFFF;
      else if (sum_v < -34'sh0_8000_0000) psat = -32'sh8000_0000;
      else psat = sum_v[31:0];
      thr_s    = $signed({2'b00, thr_ff});
      psat_neg = -33'(psat);
      fire_c   = ((33'(psat) >= thr_s) || (bthr_ff && (psat_neg >= thr_s)))
                 && (t_ff >= rd_rend_ff);
      fneg_c   = psat[31];
      pnew_wide = fneg_c ? (33'(psat) + thr_s) : (33'(psat) - thr_s);
      pnew     = fire_c ? pnew_wide[31:0] : psat;
      if (fneg_c) cnew = (rd_cnt_ff != -16'sd32768) ? rd_cnt_ff - 16'sd1 : rd_cnt_ff;
      else cnew = (rd_cnt_ff != 16'sd32767) ? rd_cnt_ff + 16'sd1 : rd_cnt_ff;
      scan_v = 17'(rd_cnt_ff);
      lead   = 18'(top_ff) - 18'(sec_ff);
   end

   always_comb begin
      sts           = '0;
      sts.clr_last  = clr_idx_ff == LAST_IDX;
      sts.in_range  = in_range;
      sts.leak_on   = leak_ff != 32'd0;
      sts.div_last  = div_cnt_ff == 6'(DIV_STEPS - 1);
      sts.dec_last  = dec_idx_ff == 5'(DEC_STEPS - 1);
      sts.need_scan = fire_c && (delta_ff != 16'd0);
      sts.scan_last = sc_idx_ff == LAST_IDX;
      sts.out_free  = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leak_ff  <= '0;
         refr_ff  <= '0;
         thr_ff   <= 31'd65536;
         off_ff   <= '0;
         bint_ff  <= 1'b0;
         bthr_ff  <= 1'b0;
         delta_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEAK_TIME:           leak_ff  <= csr_wdata;
            CSR_REFRACTORY_TIME:     refr_ff  <= csr_wdata;
            CSR_SCALED_THRESHOLD:    thr_ff   <= csr_wdata[30:0];
            CSR_BIPOLAR_OFFSET:      off_ff   <= csr_wdata[30:0];
            CSR_BIPOLAR_INTEGRATION: bint_ff  <= csr_wdata[0];
            CSR_BIPOLAR_THRESHOLD:   bthr_ff  <= csr_wdata[0];
            CSR_TERMINATE_DELTA:     delta_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr && !sts.clr_last) begin
         clr_idx_ff <= clr_idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         pot_mem[clr_idx_ff]  <= '0;
         last_mem[clr_idx_ff] <= '0;
         rend_mem[clr_idx_ff] <= '0;
         cnt_mem[clr_idx_ff]  <= '0;
      end else if (cmd.update) begin
         pot_mem[n_addr]  <= pnew;
         last_mem[n_addr] <= t_ff;
         if (fire_c) begin
            rend_mem[n_addr] <= t_ff + 40'(refr_ff);
            cnt_mem[n_addr]  <= cnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_pot_ff  <= pot_mem[n_addr];
         rd_last_ff <= last_mem[n_addr];
         rd_rend_ff <= rend_mem[n_addr];
      end
      if (cmd.rd) begin
         rd_cnt_ff <= cnt_mem[n_addr];
      end else if (cmd.scan) begin
         rd_cnt_ff <= cnt_mem[sc_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= req_neuron;
         neg_ff <= req_negative;
         t_ff   <= req_arrival_time;
         w_ff   <= req_weight;
      end
      if (cmd.start) begin
         p_ff       <= rd_pot_ff;
         quo_ff     <= {dt, 16'd0};
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= trial_ge ? (trial - {1'b0, leak_ff}) : trial;
         quo_ff     <= {quo_ff[54:0], trial_ge};
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
      if (cmd.dec_init) begin
         f_ff       <= '0;
         f_one_ff   <= 1'b1;
         zero_ff    <= quo_ff > DECAY_LIMIT;
         dec_idx_ff <= '0;
      end
      if (cmd.dec_step) begin
         if (quo_ff[0]) begin
            f_ff     <= f_one_ff ? lif_decay_tab(dec_idx_ff) : dec_round[63:32];
            f_one_ff <= 1'b0;
         end
         quo_ff     <= {1'b0, quo_ff[55:1]};
         dec_idx_ff <= dec_idx_ff + 5'd1;
      end
      if (cmd.scale) begin
         if (zero_ff) p_ff <= '0;
         else if (!f_one_ff) p_ff <= p_ff[31] ? (~mag2 + 32'd1) : mag2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         top_ff    <= CNT_FLOOR;
         sec_ff    <= CNT_FLOOR;
         sc_idx_ff <= '0;
         sv_ff     <= 1'b0;
      end else begin
         if (cmd.scan) begin
            sv_ff <= 1'b1;
            if (!sts.scan_last) sc_idx_ff <= sc_idx_ff + AW'(1);
         end
         if ((cmd.scan || cmd.scan_end) && sv_ff) begin
            if (scan_v > top_ff) begin
               sec_ff <= top_ff;
               top_ff <= scan_v;
            end else if (scan_v > sec_ff) begin
               sec_ff <= scan_v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fired_ff <= 1'b0;
         fneg_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (cmd.start) begin
         fired_ff <= 1'b0;
         fneg_ff  <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (cmd.update) begin
         fired_ff <= fire_c;
         fneg_ff  <= fire_c && fneg_c;
      end else if (cmd.fin) begin
         stop_ff <= lead >= $signed({2'b00, delta_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_fired_ff <= fired_ff;
         out_fneg_ff  <= fneg_ff;
         out_stop_ff  <= stop_ff;
         out_n_ff     <= n_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_fired          = out_fired_ff;
   assign rsp_fired_negative = out_fneg_ff;
   assign rsp_fired_neuron   = out_n_ff;
   assign rsp_stop           = out_stop_ff;

endmodule

FILE: hdl/leaky_integrate_fire_neuron_array.sv
// Item accept to rsp.valid: read, load, then with leak enabled the 56-step divider and
// 22-step decay multiply and a scale step, then update; a fire with nonzero terminate delta
// adds a count scan. One item at a time; the next item can be accepted in the cycle after
// the result is registered. Synchronous reset starts a clearing pass over all entries of
// the state memories; req.ready stays low during it.
module leaky_integrate_fire_neuron_array #(
   parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lif_req_if.sink     req,
   lif_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import lif_pkg::*;

   lif_cmd_type cmd;
   lif_sts_type sts;

   lif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lif_dp #(.NEURONS(NEURONS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_neuron         (req.neuron),
      .req_negative       (req.negative),
      .req_arrival_time   (req.arrival_time),
      .req_weight         (req.weight),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_fired          (rsp.fired),
      .rsp_fired_negative (rsp.fired_negative),
      .rsp_fired_neuron   (rsp.fired_neuron),
      .rsp_stop           (rsp.stop)
   );

endmodule

FILE: hdl/lif_checker.sv
// Port-level assertions for the LIF neuron array, bound to the top level.
// Depends on leaky_integrate_fire_neuron_array and the channel interfaces.
module lif_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_fired,
   input logic       rsp_fired_negative,
   input logic [5:0] rsp_fired_neuron,
   input logic       rsp_stop
);

   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("item taken or result shown right after reset");

   a_stop_needs_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop |-> rsp_fired)
      else $error("stop without fire");

   a_neg_needs_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired_negative |-> rsp_fired)
      else $error("negative polarity without fire");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_neuron)
         && $stable(rsp_fired) && $stable(rsp_stop))
      else $error("stalled result changed");

endmodule

bind leaky_integrate_fire_neuron_array lif_checker u_lif_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_fired          (rsp.fired),
   .rsp_fired_negative (rsp.fired_negative),
   .rsp_fired_neuron   (rsp.fired_neuron),
   .rsp_stop           (rsp.stop)
);
